>>> rtl/assert_macros.svh
// Assertion macros for the rule table checker.
// Expects clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define FMPRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds.
`define FMPRT_NEVER(label, cond, msg) \
  `FMPRT_ASSERT(label, !(cond), msg)
`endif

>>> rtl/fmprt_pkg.sv
// Shared types and codes of the first-match rule table.
// No dependencies.
package fmprt_pkg;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [6:0] COUNT_MAX = 7'h7F;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] rule_tag;
    logic [15:0] after_tag;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [31:0] src_port_range;
    logic [31:0] dst_port_range;
    logic [7:0]  protocol;
    logic        action;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        matched;
    logic [15:0] match_tag;
    logic        match_action;
    logic [6:0]  deleted_count;
  } result_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [31:0] src_range;
    logic [31:0] dst_range;
    logic [15:0] tag;
    logic [7:0]  protocol;
    logic        action;
  } rule_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WALK_START, S_WALK, S_WRITE, S_LINK, S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_next;
    logic free_found;
    logic read_head;
    logic read_next;
    logic take_match;
    logic del_step;
    logic record_pos;
    logic write_rule;
    logic link_rule;
    logic set_full;
    logic set_notfound;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] in_mode;
    logic [1:0] mode;
    logic       head_empty;
    logic       after_zero;
    logic       slot_free;
    logic       scan_last;
    logic       node_hit;
    logic       after_eq;
    logic       nx_end;
    logic       pos_found;
  } dp_status_t;

endpackage

>>> rtl/fmprt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fmprt_ctrl.sv
// Sequencer of the rule table: scan, list walk, write and link steps.
// Depends on fmprt_pkg.
module fmprt_ctrl import fmprt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t st,
  output ctl_cmd_t   cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          unique case (st.in_mode) inside
            MODE_LOOKUP, MODE_DELETE:
              state_next = st.head_empty ? S_DONE : S_WALK_START;
            MODE_INSERT: state_next = S_SCAN;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (st.slot_free) begin
          cmd.free_found = 1'b1;
          state_next = (st.head_empty || st.after_zero) ? S_WRITE : S_WALK_START;
        end else if (st.scan_last) begin
          cmd.set_full = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_WALK_START: begin
        cmd.read_head = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        unique case (st.mode)
          MODE_LOOKUP: begin
            if (st.node_hit) begin
              cmd.take_match = 1'b1;
              state_next = S_DONE;
            end else if (st.nx_end) begin
              state_next = S_DONE;
            end else begin
              cmd.read_next = 1'b1;
            end
          end
          MODE_INSERT: begin
            if (st.after_eq) begin
              cmd.record_pos = 1'b1;
              state_next = S_WRITE;
            end else if (st.nx_end) begin
              cmd.set_notfound = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.read_next = 1'b1;
            end
          end
          default: begin
            cmd.del_step = 1'b1;
            if (st.nx_end) begin
              state_next = S_DONE;
            end else begin
              cmd.read_next = 1'b1;
            end
          end
        endcase
      end
      S_WRITE: begin
        cmd.write_rule = 1'b1;
        state_next = st.pos_found ? S_LINK : S_DONE;
      end
      S_LINK: begin
        cmd.link_rule = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/fmprt_datapath.sv
// Datapath of the rule table: rule and successor memories, list head,
// slot bitmap, walk pointers and result word. Depends on fmprt_pkg, fmprt_ram.
module fmprt_datapath import fmprt_pkg::*; #(
  parameter int RULE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      cmd_in,
  input  ctl_cmd_t   cmd,
  output dp_status_t st,
  output result_t    result
);

  localparam int IDX_W = $clog2(RULE_DEPTH);
  localparam int PTR_W = $clog2(RULE_DEPTH + 1);
  localparam logic [PTR_W-1:0] EMPTY = PTR_W'(RULE_DEPTH);

  item_t                 item;
  result_t               res;
  logic [PTR_W-1:0]      head, cur, prev, pos, pos_nx;
  logic                  pos_found;
  logic [RULE_DEPTH-1:0] in_use;
  logic [IDX_W-1:0]      scan_idx, free_slot;

  rule_t            rule_rd, rule_wr;
  logic [PTR_W-1:0] succ_rd, succ_wdata, nx, raddr;
  logic [IDX_W-1:0] succ_waddr;
  logic             succ_we, tag_del_eq, sp_ok, dp_ok, proto_ok;

  // Clamp the successor to the empty marker
  assign nx = (succ_rd >= EMPTY) ? EMPTY : succ_rd;
  assign raddr = cmd.read_head ? head : nx;

  // Rule word to store
  always_comb begin
    rule_wr.src_addr  = item.src_addr;
    rule_wr.src_mask  = item.src_mask;
    rule_wr.dst_addr  = item.dst_addr;
    rule_wr.dst_mask  = item.dst_mask;
    rule_wr.src_range = item.src_port_range;
    rule_wr.dst_range = item.dst_port_range;
    rule_wr.tag       = item.rule_tag;
    rule_wr.protocol  = item.protocol;
    rule_wr.action    = item.action;
  end

  // Successor write port: new rule, link after position, or unlink
  always_comb begin
    succ_we    = 1'b0;
    succ_waddr = free_slot;
    succ_wdata = pos_found ? pos_nx : head;
    if (cmd.write_rule) begin
      succ_we = 1'b1;
    end else if (cmd.link_rule) begin
      succ_we    = 1'b1;
      succ_waddr = pos[IDX_W-1:0];
      succ_wdata = PTR_W'(free_slot);
    end else if (cmd.del_step && tag_del_eq && prev != EMPTY) begin
      succ_we    = 1'b1;
      succ_waddr = prev[IDX_W-1:0];
      succ_wdata = nx;
    end
  end

  fmprt_ram #(.WIDTH($bits(rule_t)), .DEPTH(RULE_DEPTH)) u_rule_ram (
    .clk   (clk),
    .we    (cmd.write_rule),
    .waddr (free_slot),
    .wdata (rule_wr),
    .raddr (raddr[IDX_W-1:0]),
    .rdata (rule_rd)
  );

  fmprt_ram #(.WIDTH(PTR_W), .DEPTH(RULE_DEPTH)) u_succ_ram (
    .clk   (clk),
    .we    (succ_we),
    .waddr (succ_waddr),
    .wdata (succ_wdata),
    .raddr (raddr[IDX_W-1:0]),
    .rdata (succ_rd)
  );

  // Match test of the node under the walk pointer
  assign sp_ok = item.src_port_range[15:0] >= rule_rd.src_range[31:16] &&
                 item.src_port_range[15:0] <= rule_rd.src_range[15:0];
  assign dp_ok = item.dst_port_range[15:0] >= rule_rd.dst_range[31:16] &&
                 item.dst_port_range[15:0] <= rule_rd.dst_range[15:0];
  assign proto_ok = rule_rd.protocol == 8'd0 || rule_rd.protocol == item.protocol;
  assign tag_del_eq = rule_rd.tag == item.rule_tag;

  always_comb begin
    st.in_mode    = cmd_in.mode;
    st.mode       = item.mode;
    st.head_empty = head == EMPTY;
    st.after_zero = item.after_tag == 16'd0;
    st.slot_free  = !in_use[scan_idx];
    st.scan_last  = scan_idx == IDX_W'(RULE_DEPTH - 1);
    st.node_hit   = ((item.src_addr & rule_rd.src_mask) ==
                     (rule_rd.src_addr & rule_rd.src_mask)) &&
                    ((item.dst_addr & rule_rd.dst_mask) ==
                     (rule_rd.dst_addr & rule_rd.dst_mask)) &&
                    sp_ok && dp_ok && proto_ok;
    st.after_eq   = rule_rd.tag == item.after_tag;
    st.nx_end     = nx == EMPTY;
    st.pos_found  = pos_found;
  end

  // Control registers: list head and slot bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= EMPTY;
      in_use <= '0;
    end else begin
      if (cmd.write_rule) begin
        in_use[free_slot] <= 1'b1;
        if (!pos_found) begin
          head <= PTR_W'(free_slot);
        end
      end
      if (cmd.del_step && tag_del_eq) begin
        in_use[cur[IDX_W-1:0]] <= 1'b0;
        if (prev == EMPTY) begin
          head <= nx;
        end
      end
    end
  end

  // Item, walk pointers and result word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item      <= cmd_in;
      res       <= '0;
      pos_found <= 1'b0;
      prev      <= EMPTY;
      scan_idx  <= '0;
    end
    if (cmd.scan_next) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.free_found) begin
      free_slot <= scan_idx;
    end
    if (cmd.read_head || cmd.read_next) begin
      cur <= raddr;
    end
    if (cmd.take_match) begin
      res.matched      <= 1'b1;
      res.match_tag    <= rule_rd.tag;
      res.match_action <= rule_rd.action;
    end
    if (cmd.del_step) begin
      if (tag_del_eq) begin
        if (res.deleted_count != COUNT_MAX) begin
          res.deleted_count <= res.deleted_count + 1'b1;
        end
      end else begin
        prev <= cur;
      end
    end
    if (cmd.record_pos) begin
      pos       <= cur;
      pos_nx    <= nx;
      pos_found <= 1'b1;
    end
    if (cmd.set_full) begin
      res.status <= ST_FULL;
    end
    if (cmd.set_notfound) begin
      res.status <= ST_NOT_FOUND;
    end
  end

  assign result = res;

endmodule

>>> rtl/first_match_packet_rule_table_core.sv
// First-match rule table: ordered rule list in slot memory, one word at a time.
// A lookup or delete on an empty list and mode 3 end at once; lookup and delete walk the
// list node by node; insert scans the slot bitmap for the lowest free slot, ends there if
// the table is full, and else walks to the after-tag unless the rule goes in at the head.
// The next word is taken in the cycle after the strobe.
// Synchronous reset empties the list and frees every slot; the strobe cannot be stalled.
module first_match_packet_rule_table_core import fmprt_pkg::*; #(
  parameter int RULE_DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  ctl_cmd_t   ctl;
  dp_status_t st;

  fmprt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (ctl),
    .busy  (busy),
    .done  (done)
  );

  fmprt_datapath #(.RULE_DEPTH(RULE_DEPTH)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd),
    .cmd    (ctl),
    .st     (st),
    .result (result)
  );

endmodule

>>> rtl/fmprt_checker.sv
// Port-level checks of the rule table core, bound to the top level.
// Depends on fmprt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fmprt_checker import fmprt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // An accepted word makes the core busy
  `FMPRT_ASSERT(a_accept_busy, start && !busy |=> busy, "core not busy after accept")
  // The core is free right after the strobe
  `FMPRT_ASSERT(a_done_idle, done |=> !busy && !done, "core still busy after done")
  // No strobe while idle
  `FMPRT_NEVER(a_idle_done, done && !busy, "done while idle")
  // A match carries no error and no delete count
  `FMPRT_ASSERT(a_match_clean,
    done && result.matched |-> result.status == ST_OK && result.deleted_count == 7'd0,
    "match result with stray fields")

endmodule

bind first_match_packet_rule_table_core fmprt_checker u_chk (.*);

>>> sim/rule_table_checker.sv
// Checker for the first-match rule table: watches accepted command words and
// result strobes, predicts each result from its own copy of the rule list.
// Depends on fmprt_pkg.
`timescale 1ns / 100ps
module rule_table_checker import fmprt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   cmd,
  input  logic    done,
  input  result_t result,
  output int      fail_count,
  output int      pending
);

  rule_t   slots [DEPTH];
  int      succ [DEPTH];
  bit      used [DEPTH];
  int      head;
  result_t awaited_results [$];

  // Apply one command word to the shadow list and return its result.
  function automatic result_t apply_word(item_t w);
    result_t r;
    int s, fr, pos, prev, nx, cnt;
    r = '0;
    s = head;
    if (w.mode == MODE_LOOKUP) begin
      for (int i = 0; i < DEPTH && s < DEPTH; i++) begin
        if (((w.src_addr & slots[s].src_mask) == (slots[s].src_addr & slots[s].src_mask)) &&
            ((w.dst_addr & slots[s].dst_mask) == (slots[s].dst_addr & slots[s].dst_mask)) &&
            w.src_port_range[15:0] >= slots[s].src_range[31:16] &&
            w.src_port_range[15:0] <= slots[s].src_range[15:0] &&
            w.dst_port_range[15:0] >= slots[s].dst_range[31:16] &&
            w.dst_port_range[15:0] <= slots[s].dst_range[15:0] &&
            (slots[s].protocol == 0 || slots[s].protocol == w.protocol)) begin
          r.matched = 1'b1;
          r.match_tag = slots[s].tag;
          r.match_action = slots[s].action;
          break;
        end
        s = succ[s];
      end
    end else if (w.mode == MODE_INSERT) begin
      fr = DEPTH;
      pos = DEPTH;
      for (int i = 0; i < DEPTH; i++)
        if (!used[i]) begin
          fr = i;
          break;
        end
      if (fr == DEPTH) r.status = ST_FULL;
      else begin
        if (head != DEPTH && w.after_tag != 0) begin
          for (int i = 0; i < DEPTH && s < DEPTH; i++) begin
            if (slots[s].tag == w.after_tag) begin
              pos = s;
              break;
            end
            s = succ[s];
          end
          if (pos == DEPTH) r.status = ST_NOT_FOUND;
        end
        if (r.status == ST_OK) begin
          slots[fr] = '{w.src_addr, w.src_mask, w.dst_addr, w.dst_mask, w.src_port_range,
                        w.dst_port_range, w.rule_tag, w.protocol, w.action};
          if (pos == DEPTH) begin
            succ[fr] = head;
            head = fr;
          end else begin
            succ[fr] = succ[pos];
            succ[pos] = fr;
          end
          used[fr] = 1'b1;
        end
      end
    end else if (w.mode == MODE_DELETE) begin
      prev = DEPTH;
      cnt = 0;
      for (int i = 0; i < DEPTH && s < DEPTH; i++) begin
        nx = succ[s];
        if (slots[s].tag == w.rule_tag) begin
          if (prev == DEPTH) head = nx;
          else succ[prev] = nx;
          used[s] = 1'b0;
          cnt++;
        end else prev = s;
        s = nx;
      end
      r.deleted_count = (cnt > COUNT_MAX) ? COUNT_MAX : cnt[6:0];
    end
    return r;
  endfunction

  assign pending = awaited_results.size();

  // Predict on acceptance, compare on strobe.
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      head = DEPTH;
      for (int i = 0; i < DEPTH; i++) begin
        used[i] = 1'b0;
        succ[i] = DEPTH;
      end
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result strobe with no word outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = awaited_results.pop_front();
          if (result.status !== e.status)
            $error("status: expected %0d got %0d", e.status, result.status);
          if (result.matched !== e.matched)
            $error("matched: expected %0d got %0d", e.matched, result.matched);
          if (result.match_tag !== e.match_tag)
            $error("match_tag: expected %0h got %0h", e.match_tag, result.match_tag);
          if (result.match_action !== e.match_action)
            $error("match_action: expected %0d got %0d", e.match_action,
                   result.match_action);
          if (result.deleted_count !== e.deleted_count)
            $error("deleted_count: expected %0d got %0d", e.deleted_count,
                   result.deleted_count);
          if (result !== e) fail_count <= fail_count + 1;
        end
      end
      if (start && !busy) awaited_results.push_back(apply_word(cmd));
    end
  end

endmodule

>>> sim/testbench.sv
// Stimulus and verdict for the first-match rule table core.
// Depends on fmprt_pkg, first_match_packet_rule_table_core, rule_table_checker.
`timescale 1ns / 100ps
module testbench;
  import fmprt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   cmd = '0;
  logic    busy, done;
  result_t result;
  int      fail_count, pending;
  int      idle_pct = 0;
  int      quiet_cycles = 0;
  logic [15:0] tag_pool [8] = '{16'h0001, 16'h0002, 16'h0003, 16'h00FF,
                                16'h8000, 16'hFFFF, 16'h1234, 16'hFFFE};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_match_packet_rule_table_core dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  rule_table_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  // End the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one word and hold it until accepted, with random sender gaps.
  task automatic send_word(item_t w);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and hold until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_tag();
    return ($urandom_range(3) == 0) ? 16'($urandom) : tag_pool[$urandom_range(7)];
  endfunction

  // Build a rule with random content, mostly narrow masks and sane ranges.
  function automatic item_t rand_rule();
    item_t w;
    logic [15:0] a, b;
    w = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    w.mode = MODE_INSERT;
    w.rule_tag = pick_tag();
    w.after_tag = ($urandom_range(2) == 0) ? 16'h0 : pick_tag();
    if ($urandom_range(1)) w.src_mask = 32'hFFFF_FFFF << $urandom_range(32);
    if ($urandom_range(1)) w.dst_mask = 32'hFFFF_FFFF << $urandom_range(32);
    if ($urandom_range(3) != 0) begin
      a = 16'($urandom); b = 16'($urandom);
      w.src_port_range = (a < b) ? {a, b} : {b, a};
      a = 16'($urandom); b = 16'($urandom);
      w.dst_port_range = (a < b) ? {a, b} : {b, a};
    end
    if ($urandom_range(1)) w.protocol = 8'h0;
    return w;
  endfunction

  function automatic item_t rand_word();
    item_t w;
    int r;
    r = $urandom_range(99);
    w = rand_rule();
    if (r < 40) w.mode = MODE_INSERT;
    else if (r < 85) begin
      w.mode = MODE_LOOKUP;
      w.protocol = $urandom_range(3) == 0 ? 8'd6 : 8'($urandom);
      w.src_port_range = $urandom;
      w.dst_port_range = $urandom;
    end else if (r < 97) w.mode = MODE_DELETE;
    else w.mode = MODE_UNUSED;
    return w;
  endfunction

  initial begin
    item_t w;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty lookup, insert at head on empty list, tag not found.
    w = '0;
    w.mode = MODE_LOOKUP;
    send_word(w);
    w = '1;
    w.mode = MODE_INSERT;
    w.rule_tag = 16'hFFFF;
    w.after_tag = 16'h7777;
    w.src_port_range = 32'h0000_FFFF;
    w.dst_port_range = 32'h0000_FFFF;
    send_word(w);
    w.after_tag = 16'h7777;
    w.rule_tag = 16'h0002;
    send_word(w);
    w = '0;
    w.mode = MODE_INSERT;
    w.rule_tag = 16'h0001;
    w.after_tag = 16'hFFFF;
    w.src_port_range = 32'h0010_0020;
    w.dst_port_range = 32'hFFFF_FFFF;
    send_word(w);
    w = '1;
    w.mode = MODE_LOOKUP;
    w.src_port_range = 32'h0000_0015;
    send_word(w);
    w.src_port_range = 32'hFFFF_0010;
    send_word(w);
    w.mode = MODE_UNUSED;
    send_word(w);
    w = '0;
    w.mode = MODE_DELETE;
    w.rule_tag = 16'hFFFF;
    send_word(w);
    w.rule_tag = 16'h0000;
    send_word(w);
    // Fill the table with one tag, overflow it, then delete all at once.
    w = '0;
    w.mode = MODE_INSERT;
    w.rule_tag = 16'h0000;
    repeat (66) send_word(w);
    w.mode = MODE_DELETE;
    send_word(w);
    send_word(w);
    wait_drained();

    // Random phases with different sender gaps.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 83 : (ph == 3) ? 30 : 0;
      for (int n = 0; n < 330; n++) send_word(rand_word());
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
